FILE: hw/rtl/tsli_pkg.sv
// Package for the table search linear interpolator.
// Holds table geometry constants, cmd/status codes, and divider request/response types.
// No dependencies.
`default_nettype none
package tsli_pkg;
    localparam int TABLE_DEPTH   = 1024;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = 11;
    localparam int COARSE_STRIDE = 10;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 66;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_GIVEN  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BELOW = 2'd1,
        ST_ABOVE = 2'd2,
        ST_EQUAL = 2'd3
    } status_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DATA_W:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
        logic [DATA_W:0]   rem;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: hw/rtl/table_search_linear_interpolator_unit.sv
// Top level of the table search linear interpolator.
// Usage:
//   s_ channel takes one word: cmd, row_index, key_value, table_value.
//   m_ channel returns one word per input: result_value, interval_index, status.
//   cfg_we/cfg_data write entry_count (clamped to 2..1024 in use); write only when idle.
//   Loads (cmd 0) and unused commands go from acceptance straight to the output state.
//   Search (cmd 1) reads the first key, then the last; a key outside them skips the scans.
//   Otherwise it steps the coarse scan one key at a time (up to 102 keys), the fine
//   scan one key at a time (up to 10 keys), reads the interval rows, multiplies, then
//   runs the serial divider. Given-interval interpolation (cmd 2) skips the scans;
//   equal keys or a zero product skip the divider. The single-port key and value
//   memories (registered reads) set the scan pace; the divider sets the tail.
//   One word is processed at a time; s_ready is low from acceptance until the result
//   word leaves the output register and rises the cycle after. A stalled m_ready
//   holds the result.
//   Reset (synchronous, active low) clears control and sets entry_count to 1024;
//   the table memories are undefined until loaded.
// Depends on tsli_pkg and tsli_divider.
`default_nettype none
module table_search_linear_interpolator_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [tsli_pkg::CNT_W-1:0]    cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_cmd,
    input  wire logic [tsli_pkg::IDX_W-1:0]    s_row_index,
    input  wire logic signed [31:0]            s_key_value,
    input  wire logic signed [31:0]            s_table_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [31:0]                 m_result_value,
    output logic [tsli_pkg::IDX_W-1:0]         m_interval_index,
    output logic [1:0]                         m_status
);
    import tsli_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FIRST  = 11'b00000000010,
        S_LAST   = 11'b00000000100,
        S_COARSE = 11'b00000001000,
        S_FINE   = 11'b00000010000,
        S_RD_L   = 11'b00000100000,
        S_RD_R   = 11'b00001000000,
        S_MUL    = 11'b00010000000,
        S_DIV    = 11'b00100000000,
        S_OUT    = 11'b01000000000,
        S_WAIT   = 11'b10000000000
    } state_t;

    logic [DATA_W-1:0] key_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] val_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] key_rd_reg, val_rd_reg;
    logic [IDX_W-1:0]  addr;
    logic              mem_we;

    state_t             state_reg, state_next;
    logic               phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         cmd_reg;
    logic [IDX_W-1:0]   row_reg;
    logic signed [31:0] x_reg;
    logic [IDX_W:0]     ptr_reg, ptr_next;
    logic [IDX_W:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]   left_reg, left_next;
    logic [1:0]         st_reg, st_next;
    logic signed [32:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [33:0] dx_reg, dx_next, dy_reg, dy_next, dk_reg, dk_next;
    logic               neg_reg, neg_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [31:0] res_reg, res_next;
    logic               ov_reg, ov_next;
    logic               mvalid_reg;

    logic [CNT_W-1:0]   n_eff;
    logic [IDX_W:0]     n_m1, n_m2;
    logic signed [31:0] key_s;
    logic               x_lt_key;
    div_req_t           dreq;
    div_rsp_t           drsp;
    logic [DATA_W-1:0]  mdk;
    logic [PROD_W-1:0]  q_rnd;
    logic signed [PROD_W+1:0] sum;
    logic [IDX_W:0]     left_sat;

    tsli_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    always_comb begin
        n_eff = count_reg;
        if (count_reg < CNT_W'(2)) n_eff = CNT_W'(2);
        if (count_reg > CNT_W'(TABLE_DEPTH)) n_eff = CNT_W'(TABLE_DEPTH);
        n_m1    = (IDX_W+1)'(n_eff - 1'b1);
        n_m2    = (IDX_W+1)'(n_eff - 2'd2);
    end

    assign key_s    = $signed(key_rd_reg);
    assign x_lt_key = x_reg < key_s;
    assign mdk      = dk_reg[33] ? 32'(-dk_reg) : 32'(dk_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[addr] <= s_key_value;
            val_mem[addr] <= s_table_value;
        end
        key_rd_reg <= key_mem[addr];
        val_rd_reg <= val_mem[addr];
    end

    always_comb begin
        state_next = state_reg;
        phase_next = 1'b0;
        ptr_next   = ptr_reg;
        hi_next    = hi_reg;
        left_next  = left_reg;
        st_next    = st_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dk_next    = dk_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        mem_we     = 1'b0;
        addr       = ptr_reg[IDX_W-1:0];
        dreq       = '0;
        q_rnd      = drsp.quot + PROD_W'(drsp.rem >= ({1'b0, mdk} - drsp.rem));
        sum        = neg_reg ? $signed({{35{y1_reg[32]}}, y1_reg}) - $signed({2'b00, q_rnd})
                             : $signed({{35{y1_reg[32]}}, y1_reg}) + $signed({2'b00, q_rnd});
        left_sat   = ({1'b0, row_reg} > n_m2) ? n_m2 : {1'b0, row_reg};
        case (state_reg)
            S_IDLE: begin
                addr = s_row_index;
                if (s_valid) begin
                    res_next  = '0;
                    left_next = '0;
                    st_next   = ST_OK;
                    ov_next   = 1'b0;
                    case (cmd_t'(s_cmd))
                        CMD_LOAD: begin
                            mem_we     = 1'b1;
                            state_next = S_OUT;
                        end
                        CMD_SEARCH: begin
                            ptr_next   = '0;
                            state_next = S_FIRST;
                        end
                        CMD_GIVEN: state_next = S_RD_L;
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_FIRST: begin
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else if (x_lt_key) begin
                    st_next    = ST_BELOW;
                    left_next  = '0;
                    state_next = S_RD_L;
                end else begin
                    ptr_next   = n_m1;
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else if (!x_lt_key && x_reg != key_s) begin
                    st_next    = ST_ABOVE;
                    left_next  = n_m2[IDX_W-1:0];
                    state_next = S_RD_L;
                end else begin
                    ptr_next   = (IDX_W+1)'(COARSE_STRIDE);
                    state_next = S_COARSE;
                end
            end
            S_COARSE: begin
                if (ptr_reg >= {1'b0, n_eff[IDX_W-1:0]} && n_eff != CNT_W'(TABLE_DEPTH)
                    || ptr_reg >= (IDX_W+1)'(TABLE_DEPTH)) begin
                    ptr_next   = ptr_reg - (IDX_W+1)'(COARSE_STRIDE - 1);
                    hi_next    = n_m1;
                    state_next = S_FINE;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else if (x_lt_key) begin
                    ptr_next   = ptr_reg - (IDX_W+1)'(COARSE_STRIDE - 1);
                    hi_next    = ptr_reg;
                    state_next = S_FINE;
                end else begin
                    ptr_next = ptr_reg + (IDX_W+1)'(COARSE_STRIDE);
                end
            end
            S_FINE: begin
                if (ptr_reg > hi_reg) begin
                    left_next  = IDX_W'(hi_reg - 1'b1);
                    state_next = S_RD_L;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else if (x_lt_key) begin
                    left_next  = IDX_W'(ptr_reg - 1'b1);
                    state_next = S_RD_L;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_RD_L: begin
                if (cmd_reg == CMD_GIVEN && !phase_reg) begin
                    left_next = left_sat[IDX_W-1:0];
                end
                addr = (cmd_reg == CMD_GIVEN && !phase_reg) ? left_sat[IDX_W-1:0] : left_reg;
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    x1_next    = 33'(key_s);
                    y1_next    = 33'($signed(val_rd_reg));
                    state_next = S_RD_R;
                end
            end
            S_RD_R: begin
                addr = left_reg + 1'b1;
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    dx_next    = 34'(x_reg) - 34'(x1_reg);
                    dy_next    = 34'($signed(val_rd_reg)) - 34'(y1_reg);
                    dk_next    = 34'(key_s) - 34'(x1_reg);
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (dk_reg == '0) begin
                    st_next    = ST_EQUAL;
                    res_next   = 32'(y1_reg);
                    state_next = S_OUT;
                end else begin
                    neg_next   = (dx_reg[33] ^ dy_reg[33]) ^ dk_reg[33];
                    prod_next  = PROD_W'((dx_reg[33] ? 33'(-dx_reg) : 33'(dx_reg))
                                       * (dy_reg[33] ? 33'(-dy_reg) : 33'(dy_reg)));
                    state_next = S_DIV;
                    phase_next = 1'b0;
                end
            end
            S_DIV: begin
                if (!phase_reg) begin
                    if (prod_reg == '0) begin
                        res_next   = 32'(y1_reg);
                        state_next = S_OUT;
                    end else begin
                        dreq.start    = 1'b1;
                        dreq.dividend = prod_reg;
                        dreq.divisor  = {1'b0, mdk};
                        phase_next    = 1'b1;
                    end
                end else if (!drsp.done) begin
                    phase_next = 1'b1;
                end else begin
                    ov_next = q_rnd > PROD_W'(64'h2_0000_0000);
                    if (q_rnd > PROD_W'(64'h2_0000_0000)) begin
                        res_next = neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                    end else if (sum > 68'sd2147483647) begin
                        res_next = 32'sh7fff_ffff;
                    end else if (sum < -68'sd2147483648) begin
                        res_next = 32'sh8000_0000;
                    end else begin
                        res_next = 32'(sum);
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: state_next = S_WAIT;
            S_WAIT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            phase_reg  <= 1'b0;
            count_reg  <= CNT_W'(TABLE_DEPTH);
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_we) count_reg <= cfg_data;
            if (state_reg == S_OUT) mvalid_reg <= 1'b1;
            else if (m_ready) mvalid_reg <= 1'b0;
        end
        if (state_reg == S_IDLE && s_valid) begin
            cmd_reg <= s_cmd;
            row_reg <= s_row_index;
            x_reg   <= s_key_value;
        end
        ptr_reg  <= ptr_next;
        hi_reg   <= hi_next;
        left_reg <= left_next;
        st_reg   <= st_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dk_reg   <= dk_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        ov_reg   <= ov_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = mvalid_reg;
    assign m_result_value   = res_reg;
    assign m_interval_index = left_reg;
    assign m_status         = st_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_out_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT |=> m_valid) else $error("result not presented");
    a_load_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && cmd_reg == CMD_LOAD |-> m_status == ST_OK && m_result_value == 0)
        else $error("load result not zero");
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ov_reg && m_status == ST_OK && cmd_reg != CMD_LOAD
        |-> m_result_value == 32'sh7fff_ffff || m_result_value == 32'sh8000_0000)
        else $error("overflow not saturated");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/tsli_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tsli_pkg.
`default_nettype none
module tsli_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tsli_pkg::div_req_t req,
    output tsli_pkg::div_rsp_t     rsp
);
    import tsli_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] quot_reg, quot_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W:0]   dsr_reg, dsr_next;
    logic [DATA_W+1:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quot_reg[PROD_W-1]} - {1'b0, dsr_reg};
        if (req.start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(PROD_W);
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (!trial[DATA_W+1]) begin
                rem_next = trial[DATA_W:0];
            end else begin
                rem_next = {rem_reg[DATA_W-1:0], quot_reg[PROD_W-1]};
            end
            quot_next = {quot_reg[PROD_W-2:0], ~trial[DATA_W+1]};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done held");
    a_step_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !req.start |=> !busy_reg) else $error("divider woke alone");
`endif
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for table_search_linear_interpolator_unit: loads tables, runs searches and
// given-interval interpolations mostly under random idling; checks every result word.
// Depends on tsli_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb;
    import tsli_pkg::*;

    localparam int unsigned FILL_ROWS = 200;

    typedef struct {
        logic signed [31:0] value;
        logic [9:0]         idx;
        logic [1:0]         st;
    } interp_word_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CNT_W-1:0]   cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = '0;
    logic [IDX_W-1:0]   s_row_index = '0;
    logic signed [31:0] s_key_value = '0;
    logic signed [31:0] s_table_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_result_value;
    logic [IDX_W-1:0]   m_interval_index;
    logic [1:0]         m_status;

    logic signed [31:0] key_tbl [TABLE_DEPTH];
    logic signed [31:0] val_tbl [TABLE_DEPTH];
    int unsigned        entry_cnt = 1024;
    interp_word_t       pending_words[$];
    int                 fail_cnt = 0;
    bit                 bursts_on = 1'b1;
    int                 m_stall = 0;
    int                 quiet_cycles = 0;

    table_search_linear_interpolator_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_row_index      (s_row_index),
        .s_key_value      (s_key_value),
        .s_table_value    (s_table_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_value   (m_result_value),
        .m_interval_index (m_interval_index),
        .m_status         (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned used_rows();
        if (entry_cnt < 2) return 2;
        if (entry_cnt > TABLE_DEPTH) return TABLE_DEPTH;
        return entry_cnt;
    endfunction

    function automatic longint lerp(int unsigned left, longint x, output bit eq);
        longint      x1 = key_tbl[left];
        longint      x2 = key_tbl[left+1];
        longint      y1 = val_tbl[left];
        longint      y2 = val_tbl[left+1];
        longint      dx = x - x1;
        longint      dy = y2 - y1;
        longint      dk = x2 - x1;
        logic [65:0] mdx, mdy, mdk, prod, q, r;
        bit          neg;
        longint      s;
        eq = 1'b0;
        if (dk == 0) begin
            eq = 1'b1;
            return y1;
        end
        neg = ((dx < 0) != (dy < 0)) != (dk < 0);
        mdx = (dx < 0) ? -dx : dx;
        mdy = (dy < 0) ? -dy : dy;
        mdk = (dk < 0) ? -dk : dk;
        prod = mdx * mdy;
        if (prod == 0) return y1;
        q = prod / mdk;
        r = prod % mdk;
        if (r >= mdk - r) q = q + 1;
        if (q > 66'h2_0000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
        s = neg ? y1 - longint'(q) : y1 + longint'(q);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s;
    endfunction

    function automatic int unsigned find_interval(longint x, int unsigned n,
                                                  output logic [1:0] st);
        int unsigned lo, hi, left;
        st = ST_OK;
        if (x < key_tbl[0]) begin
            st = ST_BELOW;
            return 0;
        end
        if (x > key_tbl[n-1]) begin
            st = ST_ABOVE;
            return n - 2;
        end
        lo = ((n - 1) / COARSE_STRIDE) * COARSE_STRIDE;
        hi = n - 1;
        for (int unsigned i = COARSE_STRIDE; i < n; i += COARSE_STRIDE) begin
            if (x < key_tbl[i]) begin
                lo = i - COARSE_STRIDE;
                hi = i;
                break;
            end
        end
        left = hi - 1;
        for (int unsigned j = lo + 1; j <= hi; j++) begin
            if (x < key_tbl[j]) begin
                left = j - 1;
                break;
            end
        end
        return left;
    endfunction

    function automatic interp_word_t predict_word(logic [1:0] cmd, logic [9:0] row,
                                                  logic signed [31:0] key,
                                                  logic signed [31:0] val);
        interp_word_t w;
        int unsigned  n = used_rows();
        int unsigned  left;
        logic [1:0]   st;
        bit           eq;
        longint       res;
        w.value = '0;
        w.idx = '0;
        w.st = ST_OK;
        case (cmd)
            CMD_LOAD: begin
                key_tbl[row] = key;
                val_tbl[row] = val;
            end
            CMD_SEARCH: begin
                left = find_interval(key, n, st);
                res = lerp(left, key, eq);
                w.value = res[31:0];
                w.idx = left[9:0];
                w.st = eq ? ST_EQUAL : st;
            end
            CMD_GIVEN: begin
                left = (row > n - 2) ? n - 2 : row;
                res = lerp(left, key, eq);
                w.value = res[31:0];
                w.idx = left[9:0];
                w.st = eq ? ST_EQUAL : ST_OK;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [9:0] row, logic signed [31:0] key,
                             logic signed [31:0] val);
        int gap = 0;
        if (bursts_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_row_index <= row;
        s_key_value <= key;
        s_table_value <= val;
        do @(posedge aclk); while (!s_ready);
        pending_words.push_back(predict_word(cmd, row, key, val));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_entry_count(int unsigned v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= v[CNT_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        entry_cnt = v;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_ascending(int unsigned n);
        longint k = -64'sd2100000000 + $urandom_range(0, 1000000);
        int unsigned step_max = (n > 64) ? 4000000 : 60000000;
        for (int unsigned r = 0; r < n; r++) begin
            send_word(CMD_LOAD, r[9:0], k[31:0], pick_value());
            k = k + (($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, step_max));
        end
    endtask

    function automatic logic signed [31:0] query_key(int unsigned n);
        int unsigned r = $urandom_range(0, n - 2);
        longint lo = key_tbl[r];
        longint hi = key_tbl[r+1];
        if ($urandom_range(0, 9) == 0) return $urandom;
        if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? hi : lo;
        if (hi > lo) return lo + longint'($urandom_range(0, int'(hi - lo - 1)));
        return lo;
    endfunction

    task automatic random_items(int count);
        int unsigned n = used_rows();
        int unsigned r;
        int          pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_word(CMD_SEARCH, 10'($urandom), query_key(n), $urandom);
            end else if (pick < 78) begin
                send_word(CMD_GIVEN, 10'($urandom), query_key(n), $urandom);
            end else if (pick < 94) begin
                r = $urandom_range(0, n - 1);
                if ($urandom_range(0, 1) == 0)
                    send_word(CMD_LOAD, r[9:0], $urandom, $urandom);
                else
                    send_word(CMD_LOAD, r[9:0], key_tbl[r], pick_value());
            end else begin
                send_word(CMD_NONE, 10'($urandom), $urandom, $urandom);
            end
        end
    endtask

    task automatic test_table_fill();
        set_entry_count(FILL_ROWS);
        load_ascending(FILL_ROWS);
    endtask

    task automatic test_edges();
        int unsigned n = used_rows();
        send_word(CMD_SEARCH, 10'd0, 32'sh8000_0000, 32'sd0);
        send_word(CMD_SEARCH, 10'h3ff, 32'sh7fff_ffff, 32'shffff_ffff);
        send_word(CMD_SEARCH, 10'd0, key_tbl[n-1], 32'sd0);
        send_word(CMD_SEARCH, 10'd0, key_tbl[0], 32'sd0);
        send_word(CMD_SEARCH, 10'd0, key_tbl[10], 32'sd0);
        send_word(CMD_SEARCH, 10'd0, key_tbl[n-4] + 1, 32'sd0);
        send_word(CMD_GIVEN, 10'd0, key_tbl[0] - 5, 32'sd0);
        send_word(CMD_GIVEN, 10'h3ff, key_tbl[n-1] + 7, 32'sd0);
        send_word(CMD_GIVEN, 10'd100, 32'sh7fff_ffff, 32'sd0);
        send_word(CMD_NONE, 10'h3ff, 32'shffff_ffff, 32'shffff_ffff);
        send_word(CMD_LOAD, 10'd5, key_tbl[4], 32'sh1234_5678);
        send_word(CMD_SEARCH, 10'd0, key_tbl[4], 32'sd0);
        send_word(CMD_GIVEN, 10'd4, key_tbl[4] + 100, 32'sd0);
        send_word(CMD_LOAD, 10'd6, key_tbl[5] + 1, 32'sh8000_0000);
        send_word(CMD_LOAD, 10'd7, key_tbl[6] + 1, 32'sh7fff_ffff);
        send_word(CMD_GIVEN, 10'd6, 32'sh7fff_ffff, 32'sd0);
        send_word(CMD_GIVEN, 10'd6, 32'sh8000_0000, 32'sd0);
    endtask

    task automatic test_entry_count_sweep();
        int unsigned counts[6] = '{2, 17, 10, 11, FILL_ROWS, 0};
        counts[5] = $urandom_range(2, FILL_ROWS);
        foreach (counts[c]) begin
            set_entry_count(counts[c]);
            if (counts[c] <= 64) load_ascending(counts[c]);
            random_items(70);
        end
    endtask

    task automatic test_no_idling();
        set_entry_count(3);
        bursts_on = 1'b0;
        load_ascending(3);
        random_items(60);
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (bursts_on && m_stall == 0 && $urandom_range(0, 4) == 0)
            m_stall = $urandom_range(1, 10);
        m_ready <= (m_stall == 0);
        if (m_stall > 0) m_stall = m_stall - 1;
    end

    always @(posedge aclk) begin
        interp_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected");
                fail_cnt++;
            end else begin
                e = pending_words.pop_front();
                if (m_result_value !== e.value) begin
                    $error("result_value expected %0d actual %0d", e.value, m_result_value);
                    fail_cnt++;
                end
                if (m_interval_index !== e.idx) begin
                    $error("interval_index expected %0d actual %0d", e.idx, m_interval_index);
                    fail_cnt++;
                end
                if (m_status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, m_status);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 5000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_fill();
        test_edges();
        test_entry_count_sweep();
        test_no_idling();
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0 && pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/tsli_pkg.sv
hw/rtl/tsli_divider.sv
hw/rtl/table_search_linear_interpolator_unit.sv
dv/tb.sv
